// File: rtl/racd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the raised-cosine attack table for the envelope generator.
package racd_pkg;

    localparam int COS_TABLE_BITS  = 10;
    localparam int LEVEL_FRAC_BITS = 23;
    localparam int ROM_SIZE        = 1 << COS_TABLE_BITS;
    localparam int LEVEL_W         = LEVEL_FRAC_BITS + 1;
    localparam int COEF_W          = LEVEL_FRAC_BITS;
    localparam int POS_W           = 16;
    localparam int TICK_W          = 17;
    localparam int CFG_W           = 24;
    localparam int NUM_W           = POS_W + COS_TABLE_BITS;
    localparam int DIV_STEPS       = NUM_W;
    localparam int MUL_STEPS       = COEF_W;
    localparam int CNT_W           = 5;
    localparam int ADD_W           = LEVEL_W + 1;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1) << LEVEL_FRAC_BITS;
    localparam logic [TICK_W-1:0]  TICK_MAX  = '1;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_ROM,
        ST_FIN
    } state_t;

    typedef enum logic {
        OP_DIV,
        OP_MUL
    } op_t;

    typedef enum logic [1:0] {
        REG_ATTACK = 2'd0,
        REG_GUARD  = 2'd1,
        REG_FLOOR  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } alu_ctrl_t;

    typedef struct packed {
        logic busy;
    } alu_stat_t;

    typedef logic [LEVEL_W-1:0] rom_t [ROM_SIZE];

    function automatic logic [63:0] cos_q30(input logic [63:0] a);
        logic [63:0]        a2;
        logic [63:0]        term;
        logic signed [65:0] sum;
        a2   = (a * a) >> 30;
        term = Q30_ONE;
        sum  = $signed({2'b00, Q30_ONE});
        for (int k = 1; k <= 12; k++) begin
            term = ((term * a2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if ((k % 2) == 1) begin
                sum = sum - $signed({2'b00, term});
            end
            else begin
                sum = sum + $signed({2'b00, term});
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        if (sum > $signed({2'b00, Q30_ONE})) begin
            sum = $signed({2'b00, Q30_ONE});
        end
        return sum[63:0];
    endfunction

    function automatic rom_t build_rom();
        rom_t        rom;
        logic [63:0] a;
        logic [63:0] rc;
        for (int i = 0; i < ROM_SIZE; i++) begin
            if (2 * i <= ROM_SIZE) begin
                a  = (PI_Q30 * 64'(i)) >> COS_TABLE_BITS;
                rc = (Q30_ONE - cos_q30(a)) >> 1;
            end
            else begin
                a  = (PI_Q30 * 64'(ROM_SIZE - i)) >> COS_TABLE_BITS;
                rc = (Q30_ONE + cos_q30(a)) >> 1;
            end
            rom[i] = LEVEL_W'(rc >> (30 - LEVEL_FRAC_BITS));
        end
        return rom;
    endfunction

    localparam rom_t RC_ROM = build_rom();

endpackage

// File: rtl/racd_alu.sv
`timescale 1ns / 1ps
// Shared iterative unit: restoring divide and shift-add multiply on one adder.
module racd_alu (
    input  logic                                clk,
    input  logic                                rst_n,
    input  racd_pkg::alu_ctrl_t                 ctrl,
    input  logic [racd_pkg::POS_W-1:0]          pos,
    input  logic [racd_pkg::POS_W-1:0]          divisor,
    input  logic [racd_pkg::LEVEL_W-1:0]        mul_a,
    input  logic [racd_pkg::COEF_W-1:0]         mul_b,
    output racd_pkg::alu_stat_t                 stat,
    output logic [racd_pkg::NUM_W-1:0]          quotient,
    output logic [racd_pkg::LEVEL_W-1:0]        product
);

    localparam int PROD_W = racd_pkg::LEVEL_W + racd_pkg::COEF_W;

    logic                                busy_reg;
    racd_pkg::op_t                       op_reg;
    logic [racd_pkg::CNT_W-1:0]          cnt_reg;
    logic [racd_pkg::LEVEL_W-1:0]        opnd_reg;
    logic [racd_pkg::POS_W-1:0]          rem_reg;
    logic [racd_pkg::NUM_W-1:0]          num_reg;
    logic [PROD_W-1:0]                   prod_reg;

    logic [racd_pkg::POS_W:0]            rem_shift;
    logic [racd_pkg::ADD_W-1:0]          add_x;
    logic [racd_pkg::ADD_W-1:0]          add_y;
    logic                                add_sub;
    logic [racd_pkg::ADD_W:0]            add_s;
    logic                                geq;
    logic [racd_pkg::CNT_W-1:0]          last_cnt;

    assign rem_shift = {rem_reg, num_reg[racd_pkg::NUM_W-1]};

    always_comb
    begin
        unique case (op_reg)
            racd_pkg::OP_DIV:
            begin
                add_x    = racd_pkg::ADD_W'(rem_shift);
                add_y    = racd_pkg::ADD_W'(opnd_reg[racd_pkg::POS_W-1:0]);
                add_sub  = 1'b1;
                last_cnt = racd_pkg::CNT_W'(racd_pkg::DIV_STEPS - 1);
            end
            racd_pkg::OP_MUL:
            begin
                add_x    = {1'b0, prod_reg[PROD_W-1:racd_pkg::COEF_W]};
                add_y    = prod_reg[0] ? {1'b0, opnd_reg} : '0;
                add_sub  = 1'b0;
                last_cnt = racd_pkg::CNT_W'(racd_pkg::MUL_STEPS - 1);
            end
            default:
            begin
                add_x    = '0;
                add_y    = '0;
                add_sub  = 1'b0;
                last_cnt = '0;
            end
        endcase
        add_s = {1'b0, add_x} + {1'b0, add_y ^ {racd_pkg::ADD_W{add_sub}}}
              + (racd_pkg::ADD_W + 1)'(add_sub);
        geq   = add_s[racd_pkg::ADD_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            op_reg   <= racd_pkg::OP_DIV;
            cnt_reg  <= '0;
        end
        else if (ctrl.start) begin
            busy_reg <= 1'b1;
            op_reg   <= ctrl.op;
            cnt_reg  <= '0;
        end
        else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == last_cnt) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start) begin
            if (ctrl.op == racd_pkg::OP_DIV) begin
                num_reg  <= {pos, {racd_pkg::COS_TABLE_BITS{1'b0}}};
                rem_reg  <= '0;
                opnd_reg <= racd_pkg::LEVEL_W'(divisor);
            end
            else begin
                prod_reg <= PROD_W'(mul_b);
                opnd_reg <= mul_a;
            end
        end
        else if (busy_reg) begin
            if (op_reg == racd_pkg::OP_DIV) begin
                rem_reg <= geq ? add_s[racd_pkg::POS_W-1:0] : rem_shift[racd_pkg::POS_W-1:0];
                num_reg <= {num_reg[racd_pkg::NUM_W-2:0], geq};
            end
            else begin
                prod_reg <= {add_s[racd_pkg::ADD_W-1:0], prod_reg[racd_pkg::COEF_W-1:1]};
            end
        end
    end

    assign stat.busy = busy_reg;
    assign quotient  = num_reg;
    assign product   = prod_reg[PROD_W-1:racd_pkg::COEF_W];

endmodule

// File: rtl/raised_cosine_attack_exp_decay_envelope_top.sv
`timescale 1ns / 1ps
// Top level of the attack/decay envelope generator: sequencer, state and ports.
//
//  channel | signals                          | word
//  --------+----------------------------------+------------------------------
//  in      | in_valid / in_ready              | func, decay_coef
//  out     | out_valid / out_ready            | level, active
//  cfg     | cfg_we, cfg_index, cfg_data      | attack, guard, floor registers
//
// A note-on word leaves the sequencer idle. A tick in the attack runs a
// 26-step divide on the shared unit, one registered table read, one update.
// A decay tick: 23-step multiply and update; an idle tick: update only.
// in_ready is low while a tick is in work; a finished word waits in the output
// register, and the update stalls only if that register is still full.
// Reset is asynchronous and active low; state and config registers come up at their defaults.
module raised_cosine_attack_exp_decay_envelope_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              func,
    input  logic [racd_pkg::COEF_W-1:0]       decay_coef,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [racd_pkg::LEVEL_W-1:0]      level,
    output logic                              active,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [racd_pkg::CFG_W-1:0]        cfg_data
);

    racd_pkg::state_t                     state_reg, state_next;
    logic [racd_pkg::POS_W-1:0]           attack_reg;
    logic [racd_pkg::POS_W-1:0]           guard_reg;
    logic [racd_pkg::LEVEL_W-1:0]         floor_reg;

    logic [racd_pkg::LEVEL_W-1:0]         env_reg, env_next;
    logic [racd_pkg::POS_W-1:0]           pos_reg, pos_next;
    logic [racd_pkg::TICK_W-1:0]          ticks_reg, ticks_next;
    logic                                 in_att_reg, in_att_next;
    logic                                 run_reg, run_next;
    logic [racd_pkg::COEF_W-1:0]          coef_reg, coef_next;
    logic                                 out_valid_reg, out_valid_next;
    logic [racd_pkg::LEVEL_W-1:0]         out_level_reg, out_level_next;
    logic                                 out_active_reg, out_active_next;
    logic [racd_pkg::LEVEL_W-1:0]         rom_data_reg;

    racd_pkg::alu_ctrl_t                  alu_ctrl;
    racd_pkg::alu_stat_t                  alu_stat;
    logic [racd_pkg::NUM_W-1:0]           quotient;
    logic [racd_pkg::LEVEL_W-1:0]         product;

    logic [racd_pkg::POS_W-1:0]           att;
    logic [racd_pkg::TICK_W-1:0]          min_len;
    logic [racd_pkg::COS_TABLE_BITS-1:0]  rom_idx;
    logic [racd_pkg::POS_W-1:0]           pos_inc;
    logic                                 att_end;
    logic [racd_pkg::TICK_W-1:0]          ticks_inc;
    logic [racd_pkg::LEVEL_W-1:0]         lvl;
    logic                                 stop;
    logic                                 in_fire;
    logic                                 out_free;

    racd_alu u_alu (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (alu_ctrl),
        .pos      (pos_reg),
        .divisor  (att),
        .mul_a    (env_reg),
        .mul_b    (coef_reg),
        .stat     (alu_stat),
        .quotient (quotient),
        .product  (product)
    );

    assign att       = (attack_reg == '0) ? racd_pkg::POS_W'(1) : attack_reg;
    assign min_len   = racd_pkg::TICK_W'(att) + racd_pkg::TICK_W'(guard_reg);
    assign rom_idx   = (quotient[racd_pkg::NUM_W-1:racd_pkg::COS_TABLE_BITS] != '0)
                     ? '1 : quotient[racd_pkg::COS_TABLE_BITS-1:0];
    assign pos_inc   = pos_reg + 1'b1;
    assign att_end   = (pos_inc >= att) || (pos_inc == '0);
    assign ticks_inc = (ticks_reg < racd_pkg::TICK_MAX) ? ticks_reg + 1'b1 : ticks_reg;

    assign in_ready  = (state_reg == racd_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            attack_reg <= racd_pkg::POS_W'(48);
            guard_reg  <= racd_pkg::POS_W'(240);
            floor_reg  <= racd_pkg::LEVEL_W'(8389);
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                racd_pkg::REG_ATTACK: attack_reg <= cfg_data[racd_pkg::POS_W-1:0];
                racd_pkg::REG_GUARD:  guard_reg  <= cfg_data[racd_pkg::POS_W-1:0];
                racd_pkg::REG_FLOOR:  floor_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        env_next        = env_reg;
        pos_next        = pos_reg;
        ticks_next      = ticks_reg;
        in_att_next     = in_att_reg;
        run_next        = run_reg;
        coef_next       = coef_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_level_next  = out_level_reg;
        out_active_next = out_active_reg;
        alu_ctrl.start  = 1'b0;
        alu_ctrl.op     = racd_pkg::OP_DIV;
        lvl             = racd_pkg::LEVEL_ONE;
        stop            = 1'b0;

        unique case (state_reg)
            racd_pkg::ST_IDLE:
            begin
                if (in_fire) begin
                    if (func) begin
                        coef_next   = decay_coef;
                        pos_next    = '0;
                        ticks_next  = '0;
                        env_next    = '0;
                        in_att_next = 1'b1;
                        run_next    = 1'b1;
                    end
                    else if (!run_reg) begin
                        state_next = racd_pkg::ST_FIN;
                    end
                    else begin
                        alu_ctrl.start = 1'b1;
                        alu_ctrl.op    = in_att_reg ? racd_pkg::OP_DIV : racd_pkg::OP_MUL;
                        state_next     = racd_pkg::ST_CALC;
                    end
                end
            end
            racd_pkg::ST_CALC:
            begin
                if (!alu_stat.busy) begin
                    state_next = in_att_reg ? racd_pkg::ST_ROM : racd_pkg::ST_FIN;
                end
            end
            racd_pkg::ST_ROM:
            begin
                state_next = racd_pkg::ST_FIN;
            end
            racd_pkg::ST_FIN:
            begin
                if (out_free) begin
                    if (run_reg) begin
                        if (in_att_reg) begin
                            lvl         = att_end ? racd_pkg::LEVEL_ONE : rom_data_reg;
                            in_att_next = !att_end;
                            pos_next    = pos_inc;
                        end
                        else begin
                            lvl = product;
                        end
                        ticks_next      = ticks_inc;
                        stop            = !(in_att_reg && !att_end) && (lvl < floor_reg)
                                        && (ticks_inc > min_len);
                        env_next        = stop ? '0 : lvl;
                        run_next        = !stop;
                        out_level_next  = stop ? '0 : lvl;
                        out_active_next = !stop;
                    end
                    else begin
                        out_level_next  = '0;
                        out_active_next = 1'b0;
                    end
                    out_valid_next = 1'b1;
                    state_next     = racd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = racd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= racd_pkg::ST_IDLE;
            env_reg       <= '0;
            pos_reg       <= '0;
            ticks_reg     <= '0;
            in_att_reg    <= 1'b0;
            run_reg       <= 1'b0;
            coef_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            env_reg       <= env_next;
            pos_reg       <= pos_next;
            ticks_reg     <= ticks_next;
            in_att_reg    <= in_att_next;
            run_reg       <= run_next;
            coef_reg      <= coef_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_level_reg  <= out_level_next;
        out_active_reg <= out_active_next;
        rom_data_reg   <= racd_pkg::RC_ROM[rom_idx];
    end

    assign out_valid = out_valid_reg;
    assign level     = out_level_reg;
    assign active    = out_active_reg;

endmodule

// File: rtl/racd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the envelope generator and its bind to the top level.
module racd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              func,
    input logic [racd_pkg::COEF_W-1:0]       decay_coef,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [racd_pkg::LEVEL_W-1:0]      level,
    input logic                              active,
    input logic                              cfg_we,
    input logic [1:0]                        cfg_index,
    input logic [racd_pkg::CFG_W-1:0]        cfg_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(level) && $stable(active))
        else $error("output word changed while stalled");

    a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !active |-> level == '0)
        else $error("inactive voice with nonzero level");

    a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> level <= racd_pkg::LEVEL_ONE)
        else $error("level above unity");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !func |=> !in_ready)
        else $error("ready held after tick accept");

    a_note_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && func |=> in_ready)
        else $error("ready dropped after note on");

endmodule

bind raised_cosine_attack_exp_decay_envelope_top racd_checker u_racd_checker (.*);

// File: tb/raised_cosine_attack_exp_decay_envelope_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the attack/decay envelope generator with an envelope predictor.
module raised_cosine_attack_exp_decay_envelope_top_tb;

    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          SETTLE_CYC   = 40;
    localparam int          RANDOM_WORDS = 1350;
    localparam int          IDLE_PCT     = 31;
    localparam logic        FUNC_TICK    = 1'b0;
    localparam logic        FUNC_NOTE_ON = 1'b1;
    localparam logic [1:0]  REG_UNUSED   = 2'd3;

    typedef struct packed {
        logic [racd_pkg::LEVEL_W-1:0] level;
        logic                         active;
    } env_word_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic                           func;
    logic [racd_pkg::COEF_W-1:0]    decay_coef;
    logic                           out_valid;
    logic                           out_ready;
    logic [racd_pkg::LEVEL_W-1:0]   level;
    logic                           active;
    logic                           cfg_we;
    logic [1:0]                     cfg_index;
    logic [racd_pkg::CFG_W-1:0]     cfg_data;

    logic [racd_pkg::LEVEL_W-1:0]   rc_table [racd_pkg::ROM_SIZE];
    logic [racd_pkg::POS_W-1:0]     attack_len;
    logic [racd_pkg::POS_W-1:0]     guard_len;
    logic [racd_pkg::LEVEL_W-1:0]   floor_lvl;
    logic [racd_pkg::LEVEL_W-1:0]   env_q;
    logic [racd_pkg::POS_W-1:0]     pos_q;
    logic [racd_pkg::TICK_W-1:0]    tick_q;
    logic                           in_att_q;
    logic                           run_q;
    logic [racd_pkg::COEF_W-1:0]    coef_q;

    env_word_t            pending_levels [$];
    int                   errors;
    int                   words_sent;
    int                   cycle_count;
    bit                   quiet;

    raised_cosine_attack_exp_decay_envelope_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .decay_coef (decay_coef),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .level      (level),
        .active     (active),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic longint unsigned taylor_cos(input longint unsigned ang);
        longint unsigned sq;
        longint unsigned term;
        longint          sum;
        sq   = (ang * ang) >> 30;
        term = 64'd1 << 30;
        sum  = 64'sd1 << 30;
        for (int k = 1; k <= 12; k++)
        begin
            term = ((term * sq) >> 30) / longint'((2 * k - 1) * (2 * k));
            if (k % 2 == 1)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        if (sum > (64'sd1 << 30))
        begin
            sum = 64'sd1 << 30;
        end
        return longint'(sum);
    endfunction

    task automatic fill_rc_table();
        longint unsigned ang;
        longint unsigned rc;
        longint unsigned one;
        one = 64'd1 << 30;
        for (int i = 0; i < racd_pkg::ROM_SIZE; i++)
        begin
            if (2 * i <= racd_pkg::ROM_SIZE)
            begin
                ang = (64'd3373259426 * longint'(i)) >> racd_pkg::COS_TABLE_BITS;
                rc  = (one - taylor_cos(ang)) >> 1;
            end
            else
            begin
                ang = (64'd3373259426 * longint'(racd_pkg::ROM_SIZE - i))
                    >> racd_pkg::COS_TABLE_BITS;
                rc  = (one + taylor_cos(ang)) >> 1;
            end
            rc_table[i] = racd_pkg::LEVEL_W'(rc >> (30 - racd_pkg::LEVEL_FRAC_BITS));
        end
    endtask

    task automatic advance_envelope(input logic f, input logic [racd_pkg::COEF_W-1:0] c);
        int unsigned     att;
        int unsigned     min_len;
        longint unsigned idx;
        longint unsigned prod;
        att     = (attack_len == 0) ? 1 : attack_len;
        min_len = att + guard_len;
        if (f == FUNC_NOTE_ON)
        begin
            coef_q   = c;
            pos_q    = '0;
            tick_q   = '0;
            env_q    = '0;
            in_att_q = 1'b1;
            run_q    = 1'b1;
        end
        else if (!run_q)
        begin
            pending_levels.push_back('{level: '0, active: 1'b0});
        end
        else
        begin
            if (in_att_q)
            begin
                idx = (longint'(pos_q) << racd_pkg::COS_TABLE_BITS) / att;
                if (idx >= racd_pkg::ROM_SIZE)
                begin
                    idx = racd_pkg::ROM_SIZE - 1;
                end
                env_q = rc_table[idx];
                pos_q = pos_q + 1'b1;
                if (pos_q >= att || pos_q == 0)
                begin
                    in_att_q = 1'b0;
                    env_q    = racd_pkg::LEVEL_ONE;
                end
            end
            else
            begin
                prod  = longint'(env_q) * longint'(coef_q);
                env_q = racd_pkg::LEVEL_W'(prod >> racd_pkg::LEVEL_FRAC_BITS);
            end
            if (tick_q < racd_pkg::TICK_MAX)
            begin
                tick_q = tick_q + 1'b1;
            end
            if (!in_att_q && env_q < floor_lvl && tick_q > min_len)
            begin
                run_q = 1'b0;
                env_q = '0;
            end
            pending_levels.push_back('{level: env_q, active: run_q});
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        errors++;
    endtask

    task automatic send_word(input logic f, input logic [racd_pkg::COEF_W-1:0] c);
        int gap;
        gap = 0;
        if (!quiet)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                gap++;
            end
            if ($urandom_range(99) < 4)
            begin
                gap += $urandom_range(40, 1);
            end
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        decay_coef <= c;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        advance_envelope(f, c);
        words_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_levels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [racd_pkg::CFG_W-1:0] data);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            racd_pkg::REG_ATTACK: attack_len = data[racd_pkg::POS_W-1:0];
            racd_pkg::REG_GUARD:  guard_len  = data[racd_pkg::POS_W-1:0];
            racd_pkg::REG_FLOOR:  floor_lvl  = data;
            default:    ;
        endcase
    endtask

    task automatic run_voice(input logic [racd_pkg::COEF_W-1:0] c, input int max_ticks,
                             input bit to_end);
        int n;
        send_word(FUNC_NOTE_ON, c);
        n = 0;
        while (n < max_ticks && (!to_end || run_q))
        begin
            send_word(FUNC_TICK, racd_pkg::COEF_W'($urandom));
            n++;
        end
    endtask

    task automatic test_idle_ticks();
        send_word(FUNC_TICK, '0);
        send_word(FUNC_TICK, '1);
    endtask

    task automatic test_zero_attack_high_floor();
        write_reg(racd_pkg::REG_ATTACK, '0);
        write_reg(racd_pkg::REG_GUARD, '0);
        write_reg(racd_pkg::REG_FLOOR, racd_pkg::CFG_W'(racd_pkg::LEVEL_ONE));
        run_voice('1, 3, 1'b0);
    endtask

    task automatic test_zero_coef_zero_floor();
        write_reg(racd_pkg::REG_ATTACK, racd_pkg::CFG_W'(1));
        write_reg(racd_pkg::REG_FLOOR, '0);
        run_voice('0, 3, 1'b0);
    endtask

    task automatic test_length_change_mid_note();
        write_reg(racd_pkg::REG_ATTACK, '1);
        write_reg(racd_pkg::REG_GUARD, '1);
        write_reg(racd_pkg::REG_FLOOR, racd_pkg::CFG_W'(8389));
        run_voice(racd_pkg::COEF_W'(23'h600000), 4, 1'b0);
        write_reg(racd_pkg::REG_ATTACK, racd_pkg::CFG_W'(3));
        write_reg(REG_UNUSED, racd_pkg::CFG_W'($urandom));
        send_word(FUNC_TICK, '0);
        send_word(FUNC_TICK, '0);
        send_word(FUNC_TICK, '0);
    endtask

    task automatic test_retrigger();
        write_reg(racd_pkg::REG_ATTACK, racd_pkg::CFG_W'(6));
        write_reg(racd_pkg::REG_GUARD, racd_pkg::CFG_W'(2));
        run_voice(racd_pkg::COEF_W'(23'h7C0000), 2, 1'b0);
        run_voice(racd_pkg::COEF_W'(23'h200000), 1, 1'b0);
        send_word(FUNC_NOTE_ON, racd_pkg::COEF_W'(23'h555555));
    endtask

    task automatic randomize_regs();
        int          pick;
        logic [15:0] val;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            val = 16'($urandom_range(24, 1));
        end
        else if (pick < 80)
        begin
            val = 16'd0;
        end
        else if (pick < 96)
        begin
            val = 16'($urandom_range(400, 25));
        end
        else
        begin
            val = 16'($urandom_range(65535, 1000));
        end
        write_reg(racd_pkg::REG_ATTACK, {8'($urandom), val});
        pick = $urandom_range(99);
        val  = (pick < 85) ? 16'($urandom_range(40, 0)) : 16'($urandom_range(300, 0));
        write_reg(racd_pkg::REG_GUARD, {8'($urandom), val});
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            write_reg(racd_pkg::REG_FLOOR, racd_pkg::CFG_W'($urandom_range(32'h20000, 0)));
        end
        else if (pick < 80)
        begin
            write_reg(racd_pkg::REG_FLOOR,
                      racd_pkg::CFG_W'($urandom_range(racd_pkg::LEVEL_ONE, 0)));
        end
        else if (pick < 90)
        begin
            write_reg(racd_pkg::REG_FLOOR, '0);
        end
        else
        begin
            write_reg(racd_pkg::REG_FLOOR, racd_pkg::CFG_W'(racd_pkg::LEVEL_ONE));
        end
        if ($urandom_range(99) < 5)
        begin
            write_reg(REG_UNUSED, racd_pkg::CFG_W'($urandom));
        end
    endtask

    task automatic test_random_voices();
        int                          voices;
        int                          pick;
        int                          start_words;
        logic [racd_pkg::COEF_W-1:0] c;
        voices      = 0;
        start_words = words_sent;
        while (words_sent - start_words < RANDOM_WORDS)
        begin
            quiet = (words_sent - start_words > 500) && (words_sent - start_words < 800);
            if (voices % 3 == 0)
            begin
                randomize_regs();
            end
            voices++;
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                c = racd_pkg::COEF_W'($urandom_range(23'h7FFFFF, 23'h400000));
            end
            else if (pick < 85)
            begin
                c = racd_pkg::COEF_W'($urandom);
            end
            else
            begin
                c = racd_pkg::COEF_W'($urandom_range(23'h7FFFFF, 23'h780000));
            end
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                send_word(1'($urandom), racd_pkg::COEF_W'($urandom));
            end
            else if (pick < 78)
            begin
                run_voice(c, 120, 1'b1);
            end
            else
            begin
                run_voice(c, $urandom_range(40, 0), 1'b0);
            end
            repeat ($urandom_range(2, 0)) send_word(FUNC_TICK, racd_pkg::COEF_W'($urandom));
        end
        quiet = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        env_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_levels.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word level %0d active %0d", level, active));
            end
            else
            begin
                want = pending_levels.pop_front();
                if (level !== want.level)
                begin
                    report_mismatch($sformatf("level %0d, want %0d", level, want.level));
                end
                if (active !== want.active)
                begin
                    report_mismatch($sformatf("active %0d, want %0d", active, want.active));
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("raised_cosine_attack_exp_decay_envelope_top_tb: FAIL");
        $finish;
    end

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        func       <= FUNC_TICK;
        decay_coef <= '0;
        out_ready  <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= racd_pkg::REG_ATTACK;
        cfg_data   <= '0;
        errors     = 0;
        words_sent = 0;
        quiet      = 1'b0;
        attack_len = 16'd48;
        guard_len  = 16'd240;
        floor_lvl  = 24'd8389;
        env_q      = '0;
        pos_q      = '0;
        tick_q     = '0;
        in_att_q   = 1'b0;
        run_q      = 1'b0;
        coef_q     = '0;
        fill_rc_table();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_ticks();
        test_zero_attack_high_floor();
        test_zero_coef_zero_floor();
        test_length_change_mid_note();
        test_retrigger();
        test_random_voices();
        settle();
        if (errors == 0)
        begin
            $display("raised_cosine_attack_exp_decay_envelope_top_tb: PASS");
        end
        else
        begin
            $display("raised_cosine_attack_exp_decay_envelope_top_tb: FAIL");
        end
        $finish;
    end

endmodule
